>>> hw/rtl/fbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbp_pkg
// Shared types and codes of the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbp_pkg;

	localparam int ADDR_W  = 64;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 3;
	localparam int LEN_W   = 32;
	localparam int CODE_W  = 2;
	localparam int PAGES_W = 20;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;
	localparam int OUT_W   = 72;
	localparam int Q_DEPTH = 2;

	localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_SIZE   = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_MEMORY  = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_BASE   = 3'd3;
	localparam logic [STAT_W-1:0] ST_BAD_LENGTH = 3'd4;
	localparam logic [STAT_W-1:0] ST_CAPACITY   = 3'd5;
	localparam logic [STAT_W-1:0] ST_OVERFLOW   = 3'd6;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_LENGTH = 2'd1;
	localparam logic [1:0] REG_CODE   = 2'd2;

	localparam logic [CODE_W-1:0] CODE_4K = 2'd0;
	localparam logic [CODE_W-1:0] CODE_2M = 2'd1;

	localparam logic [ADDR_W-1:0] SIZE_4K = 64'h0000_0000_0000_1000;
	localparam logic [ADDR_W-1:0] SIZE_2M = 64'h0000_0000_0020_0000;

	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_INIT   = 2'd1,
		OP_ALLOC  = 2'd2,
		OP_FREE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [STAT_W-1:0]   status;
		logic                huge;
		logic [ADDR_W-1:0]   addr;
		logic [PAGES_W-1:0]  pages;
	} cmd_t;

endpackage

>>> hw/rtl/fbp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbp_front
// Holds the configuration registers, accepts request beats and classifies
// each one into a command, running the init checks up front.
// ----------------------------------------------------------------------------
module fbp_front #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fbp_pkg::ADDR_W-1:0]     s_tdata,
	input  logic [fbp_pkg::KIND_W-1:0]     s_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fbp_pkg::PADDR_W-1:0]    paddr,
	input  logic [fbp_pkg::PDATA_W-1:0]    pwdata,
	output logic [fbp_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           q_full,
	output logic                           push,
	output fbp_pkg::cmd_t                  cmd
);
	import fbp_pkg::*;

	logic [ADDR_W-1:0]  base_q;
	logic [LEN_W-1:0]   length_q;
	logic [CODE_W-1:0]  code_q;
	logic               wr_en;
	logic [PAGES_W-1:0] pages;
	logic               huge;
	logic               too_short;
	logic               base_bad;
	logic               len_bad;
	logic [STAT_W-1:0]  init_status;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			length_q <= '0;
			code_q   <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				REG_BASE:   base_q   <= pwdata;
				REG_LENGTH: length_q <= pwdata[LEN_W-1:0];
				REG_CODE:   code_q   <= pwdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_BASE:   prdata = base_q;
			REG_LENGTH: prdata = {{(PDATA_W-LEN_W){1'b0}}, length_q};
			REG_CODE:   prdata = {{(PDATA_W-CODE_W){1'b0}}, code_q};
			default:    prdata = '0;
		endcase
	end

	assign huge = (code_q == CODE_2M);

	always_comb begin
		if (huge) begin
			pages     = {9'd0, length_q[31:21]};
			too_short = (length_q[31:21] == '0);
			base_bad  = (base_q == '0) || (base_q[20:0] != '0);
			len_bad   = (length_q[20:0] != '0);
		end else begin
			pages     = length_q[31:12];
			too_short = (length_q[31:12] == '0);
			base_bad  = (base_q == '0) || (base_q[11:0] != '0);
			len_bad   = (length_q[11:0] != '0);
		end
	end

	always_comb begin
		priority if (code_q != CODE_4K && code_q != CODE_2M) begin
			init_status = ST_BAD_SIZE;
		end else if (too_short) begin
			init_status = ST_NO_MEMORY;
		end else if (base_bad) begin
			init_status = ST_BAD_BASE;
		end else if (len_bad) begin
			init_status = ST_BAD_LENGTH;
		end else if ({1'b0, pages} > (PAGES_W+1)'(MAX_BLOCKS)) begin
			init_status = ST_CAPACITY;
		end else begin
			init_status = ST_OK;
		end
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		cmd.op     = OP_REPORT;
		cmd.status = ST_OK;
		cmd.huge   = huge;
		cmd.addr   = s_tdata;
		cmd.pages  = pages;
		unique case (s_tuser)
			KIND_INIT: begin
				cmd.addr   = base_q;
				cmd.status = init_status;
				cmd.op     = (init_status == ST_OK) ? OP_INIT : OP_REPORT;
			end
			KIND_ALLOC: begin
				cmd.op = OP_ALLOC;
			end
			KIND_FREE: begin
				if (s_tdata == '0) begin
					cmd.status = ST_BAD_SIZE;
				end else begin
					cmd.op = OP_FREE;
				end
			end
			default: begin
				cmd.status = ST_BAD_SIZE;
			end
		endcase
	end

endmodule

>>> hw/rtl/fbp_cmd_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbp_cmd_q
// Short command queue between the front and the back of the allocator.
// ----------------------------------------------------------------------------
module fbp_cmd_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fbp_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          valid,
	output fbp_pkg::cmd_t head_cmd
);
	import fbp_pkg::*;

	localparam int QAW = $clog2(Q_DEPTH);
	localparam int QCW = $clog2(Q_DEPTH + 1);

	cmd_t             entry_q [Q_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;

	assign full     = (cnt_q == QCW'(Q_DEPTH));
	assign valid    = (cnt_q != '0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(Q_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(Q_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/fbp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbp_back
// Executes commands against the free-list memory: fills it on init, reads
// the head on alloc, writes the tail on free, and drives the result beat.
// ----------------------------------------------------------------------------
module fbp_back #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  fbp_pkg::cmd_t               q_cmd,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fbp_pkg::OUT_W-1:0]   m_tdata
);
	import fbp_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_FILL = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  mem_q [MAX_BLOCKS];
	logic [ADDR_W-1:0]  rd_q;
	logic [IW-1:0]      head_q, head_d;
	logic [IW-1:0]      tail_q, tail_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      fill_cnt_q, fill_cnt_d;
	logic [CW-1:0]      fill_nxt;
	logic [CW-1:0]      pages_q;
	logic [ADDR_W-1:0]  fill_addr_q;
	logic               huge_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic               out_free;
	logic               emit;
	logic [STAT_W-1:0]  emit_status;
	logic [ADDR_W-1:0]  emit_addr;
	logic               wr_en;
	logic [IW-1:0]      wr_idx;
	logic [ADDR_W-1:0]  wr_data;
	logic               rd_en;
	logic               load;

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
		return (i == IW'(MAX_BLOCKS-1)) ? '0 : i + 1'b1;
	endfunction

	assign out_free = !out_valid_q || m_tready;
	assign fill_nxt = fill_cnt_q + 1'b1;
	assign q_pop    = (state_q == S_IDLE) && q_valid && out_free;

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		fill_cnt_d  = fill_cnt_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_addr   = '0;
		wr_en       = 1'b0;
		wr_idx      = tail_q;
		wr_data     = q_cmd.addr;
		rd_en       = 1'b0;
		load        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					unique case (q_cmd.op)
						OP_REPORT: begin
							emit        = 1'b1;
							emit_status = q_cmd.status;
						end
						OP_ALLOC: begin
							if (count_q == '0) begin
								emit        = 1'b1;
								emit_status = ST_NO_MEMORY;
							end else begin
								rd_en   = 1'b1;
								head_d  = next_idx(head_q);
								count_d = count_q - 1'b1;
								state_d = S_READ;
							end
						end
						OP_FREE: begin
							emit = 1'b1;
							if (count_q == CW'(MAX_BLOCKS)) begin
								emit_status = ST_OVERFLOW;
							end else begin
								wr_en   = 1'b1;
								tail_d  = next_idx(tail_q);
								count_d = count_q + 1'b1;
							end
						end
						OP_INIT: begin
							load       = 1'b1;
							fill_cnt_d = '0;
							state_d    = S_FILL;
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_addr = rd_q;
					state_d   = S_IDLE;
				end
			end
			S_FILL: begin
				wr_en      = 1'b1;
				wr_idx     = fill_cnt_q[IW-1:0];
				wr_data    = fill_addr_q;
				fill_cnt_d = fill_nxt;
				if (fill_nxt == pages_q) begin
					head_d  = '0;
					count_d = pages_q;
					tail_d  = (pages_q == CW'(MAX_BLOCKS)) ? '0 : pages_q[IW-1:0];
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[head_q];
		end
		if (load) begin
			pages_q     <= q_cmd.pages[CW-1:0];
			huge_q      <= q_cmd.huge;
			fill_addr_q <= q_cmd.addr;
		end else if (state_q == S_FILL) begin
			fill_addr_q <= fill_addr_q + (huge_q ? SIZE_2M : SIZE_4K);
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_addr_q   <= emit_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			fill_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			count_q    <= count_d;
			fill_cnt_q <= fill_cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-ADDR_W-STAT_W){1'b0}}, out_addr_q, out_status_q};

endmodule

>>> hw/rtl/fixed_block_free_list_pool_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_pool_top
// Fixed-size page pool allocator with a FIFO free list of page addresses.
// ----------------------------------------------------------------------------
// Requests enter on the s_ group with the kind in s_tuser (0 init, 1 alloc,
// 2 free) and one result beat leaves on the m_ group for every request. A
// two-entry command queue separates request intake from execution. Once in
// the executing stage, a free, a rejected request and an alloc on an empty
// list answer from the idle state; a successful alloc goes through a read
// state, since the free-list memory has a registered read port; a successful
// init goes through fill and finish states, as the single write port stores
// one page address per cycle. Configuration registers sit at byte addresses
// 0, 8 and 16 and must only be written while no request is in flight.
module fixed_block_free_list_pool_top #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// block_address[63:0]
	input  logic [fbp_pkg::ADDR_W-1:0]   s_tdata,
	// kind[1:0]
	input  logic [fbp_pkg::KIND_W-1:0]   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[2:0], granted_address[66:3], zero[71:67]
	output logic [fbp_pkg::OUT_W-1:0]    m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fbp_pkg::PADDR_W-1:0]  paddr,
	input  logic [fbp_pkg::PDATA_W-1:0]  pwdata,
	output logic [fbp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import fbp_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic pop;
	logic q_full;
	logic q_valid;

	fbp_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	fbp_cmd_q u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.valid    (q_valid),
		.head_cmd (head_cmd)
	);

	fbp_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (head_cmd),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> hw/rtl/fbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbp_checker
// Port-level checks on the result stream of the block pool allocator.
// ----------------------------------------------------------------------------
module fbp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [fbp_pkg::OUT_W-1:0]  m_tdata
);
	import fbp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result beat changed while stalled.");

	a_zero_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[66:3] == '0)
		else $error("Failed request carries a granted address.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd7)
		else $error("Result beat carries an undefined status.");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:67] == '0)
		else $error("Result beat padding is not zero.");

endmodule

bind fixed_block_free_list_pool_top fbp_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> dv/fixed_block_free_list_pool_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_pool_top_tb
// Self-checking bench for the fixed-size page pool allocator. A short
// directed sequence walks every init check, the empty, null and full cases
// and both page sizes. It is followed by random phases, most with a new
// pool setting, that mix inits, allocs, frees and unused kinds. An in-bench
// free list predicts each result beat; the monitor compares them in order.
// ----------------------------------------------------------------------------
module fixed_block_free_list_pool_top_tb;
	import fbp_pkg::*;

	localparam int     POOL_DEPTH    = 1024;
	localparam int     CLK_PERIOD    = 10;
	localparam int     RANDOM_ITEMS  = 850;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     HOLD_CYCLES   = 400;
	localparam longint TIMEOUT_NS    = 64'd10_000_000;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [CODE_W-1:0] CODE_RSVD2  = 2'd2;
	localparam logic [CODE_W-1:0] CODE_RSVD3  = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] addr;
	} pool_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] grant;
	} pool_reply_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [ADDR_W-1:0]    s_tdata  = '0;
	logic [KIND_W-1:0]    s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [PDATA_W-1:0]   pwdata   = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	pool_req_t         pending_requests[$];
	pool_reply_t       expected_replies[$];
	logic [ADDR_W-1:0] model_free_list[$];

	logic [ADDR_W-1:0] cfg_base   = '0;
	logic [LEN_W-1:0]  cfg_length = '0;
	logic [CODE_W-1:0] cfg_code   = '0;

	int unsigned err_cnt      = 0;
	int unsigned tx_gap       = 0;
	int unsigned rx_gap       = 0;
	int unsigned rx_hold_left = 0;
	bit          tx_idle_en   = 1'b1;
	bit          rx_idle_en   = 1'b1;
	bit          req_taken    = 1'b0;
	bit          rx_hold_req  = 1'b0;
	pool_req_t   tx_item;
	pool_reply_t want_reply;

	fixed_block_free_list_pool_top #(
		.MAX_BLOCKS(POOL_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [ADDR_W-1:0] page_bytes(input logic [CODE_W-1:0] code);
		if (code == CODE_4K)
			return SIZE_4K;
		if (code == CODE_2M)
			return SIZE_2M;
		return '0;
	endfunction

	function automatic int unsigned idle_len(input bit en);
		int unsigned r;
		if (!en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	// Expected result of one accepted request, applied to the bench's own list.
	task automatic pool_predict(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
		pool_reply_t       r;
		logic [ADDR_W-1:0] page;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] p;
		r.status = ST_OK;
		r.grant  = '0;
		page     = page_bytes(cfg_code);
		len      = {32'd0, cfg_length};
		case (kind)
			KIND_INIT: begin
				if (page == '0)
					r.status = ST_BAD_SIZE;
				else if (len < page)
					r.status = ST_NO_MEMORY;
				else if (cfg_base == '0 || (cfg_base & (page - 1)) != '0)
					r.status = ST_BAD_BASE;
				else if ((len & (page - 1)) != '0)
					r.status = ST_BAD_LENGTH;
				else if (len / page > POOL_DEPTH)
					r.status = ST_CAPACITY;
				else begin
					model_free_list.delete();
					for (p = '0; p < len / page; p++)
						model_free_list.push_back(cfg_base + p * page);
				end
			end
			KIND_ALLOC: begin
				if (model_free_list.size() == 0)
					r.status = ST_NO_MEMORY;
				else
					r.grant = model_free_list.pop_front();
			end
			KIND_FREE: begin
				if (addr == '0)
					r.status = ST_BAD_SIZE;
				else if (model_free_list.size() >= POOL_DEPTH)
					r.status = ST_OVERFLOW;
				else
					model_free_list.push_back(addr);
			end
			default: begin
				r.status = ST_BAD_SIZE;
			end
		endcase
		expected_replies.push_back(r);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] mask;
		case (idx)
			REG_BASE: begin
				mask     = '1;
				cfg_base = val;
			end
			REG_LENGTH: begin
				mask       = 64'hFFFF_FFFF;
				cfg_length = val[LEN_W-1:0];
			end
			default: begin
				mask     = 64'h3;
				cfg_code = val[CODE_W-1:0];
			end
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) != (val & mask)) begin
			$error("register %0d readback: expected %h, got %h", idx, val & mask, prdata & mask);
			err_cnt++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] code);
		reg_write(REG_BASE, base);
		reg_write(REG_LENGTH, {32'd0, len});
		reg_write(REG_CODE, {62'd0, code});
	endtask

	task automatic queue_req(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
		pool_req_t q;
		q.kind = kind;
		q.addr = addr;
		pending_requests.push_back(q);
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || s_tvalid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic init_with(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] code);
		wait_idle();
		configure(base, len, code);
		queue_req(KIND_INIT, '0);
	endtask

	// Mostly valid pool settings with small page counts, plus some broken ones.
	task automatic random_setup(output int unsigned page_cnt);
		int unsigned       r;
		logic [CODE_W-1:0] code;
		logic [ADDR_W-1:0] page;
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  len;
		r    = $urandom_range(0, 99);
		code = (r < 6) ? CODE_W'($urandom_range(2, 3)) : CODE_W'($urandom_range(0, 1));
		page = (code == CODE_2M) ? SIZE_2M : SIZE_4K;
		r    = $urandom_range(0, 99);
		if (r < 65)
			page_cnt = $urandom_range(1, 16);
		else if (r < 85)
			page_cnt = $urandom_range(17, 256);
		else if (r < 92)
			page_cnt = $urandom_range(257, POOL_DEPTH);
		else if (r < 97)
			page_cnt = POOL_DEPTH;
		else
			page_cnt = $urandom_range(POOL_DEPTH + 1, POOL_DEPTH + 64);
		base = {$urandom, $urandom} & ~(page - 1);
		if (base == '0)
			base = page;
		len = LEN_W'(page_cnt) * LEN_W'(page);
		r   = $urandom_range(0, 99);
		if (r < 5)
			base = base | 64'h800;
		else if (r < 9)
			len = len + 32'h10;
		else if (r < 11)
			base = '0;
		else if (r < 13)
			len = $urandom_range(0, 32'(page) - 1);
		configure(base, len, code);
	endtask

	function automatic logic [ADDR_W-1:0] pick_free_addr(input int unsigned page_cnt);
		int unsigned       r;
		logic [ADDR_W-1:0] page;
		r    = $urandom_range(0, 99);
		page = page_bytes(cfg_code);
		if (r < 65 && page != '0)
			return cfg_base + 64'($urandom_range(0, page_cnt - 1)) * page;
		if (r < 85)
			return {$urandom, $urandom};
		if (r < 91)
			return '0;
		if (r < 95)
			return '1;
		return 64'd1 << $urandom_range(0, 63);
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			pool_predict(s_tuser, s_tdata);
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				tx_item = pending_requests.pop_front();
				s_tdata  <= tx_item.addr;
				s_tuser  <= tx_item.kind;
				s_tvalid <= 1'b1;
				tx_gap = idle_len(tx_idle_en);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	// The long hold-off lets the block fill up and push back on its input.
	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left = HOLD_CYCLES;
			rx_hold_req  = 1'b0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_gap = idle_len(rx_idle_en);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_replies.size() == 0) begin
				$error("result beat with nothing expected: status %0d, address %h",
					m_tdata[STAT_W-1:0], m_tdata[STAT_W +: ADDR_W]);
				err_cnt++;
			end else begin
				want_reply = expected_replies.pop_front();
				if (m_tdata[STAT_W-1:0] != want_reply.status) begin
					$error("status: expected %0d, got %0d", want_reply.status,
						m_tdata[STAT_W-1:0]);
					err_cnt++;
				end
				if (m_tdata[STAT_W +: ADDR_W] != want_reply.grant) begin
					$error("granted_address: expected %h, got %h", want_reply.grant,
						m_tdata[STAT_W +: ADDR_W]);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int unsigned page_cnt;
		int unsigned n;
		int unsigned i;
		int unsigned r;
		int unsigned phase;
		int unsigned rand_sent;
		page_cnt  = 1;
		phase     = 0;
		rand_sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset setting: empty list, null free, unused kind, short pool.
		queue_req(KIND_ALLOC, '0);
		queue_req(KIND_FREE, '0);
		queue_req(KIND_UNUSED, '1);
		queue_req(KIND_INIT, '1);
		queue_req(KIND_FREE, 64'h1000);
		queue_req(KIND_ALLOC, '0);

		init_with(64'h1000, 32'h1000, CODE_RSVD2);
		init_with(64'h1000, 32'h1000, CODE_RSVD3);
		init_with('0, 32'h1000, CODE_4K);
		init_with(64'h1001, 32'h1000, CODE_4K);
		init_with(64'h1000, 32'h1800, CODE_4K);
		init_with(64'h1000, 32'hFFFF_FFFF, CODE_4K);
		init_with(64'h1000, 32'hFFFF_F000, CODE_4K);

		// A full store whose page addresses wrap past the top of the space.
		init_with(64'hFFFF_FFFF_FFF0_0000, 32'h0040_0000, CODE_4K);
		queue_req(KIND_FREE, '1);
		queue_req(KIND_ALLOC, '0);
		queue_req(KIND_FREE, '1);

		init_with(64'hFFFF_FFFF_FFE0_0000, 32'h001F_FFFF, CODE_2M);
		init_with(64'h1000, 32'h0060_0000, CODE_2M);
		init_with(64'h0040_0000, 32'hFFFF_FFFF, CODE_2M);
		init_with(64'h0040_0000, 32'hFFE0_0000, CODE_2M);
		init_with(64'hFFFF_FFFF_FFE0_0000, 32'h0060_0000, CODE_2M);
		repeat (3) queue_req(KIND_ALLOC, {$urandom, $urandom});

		while (rand_sent < RANDOM_ITEMS) begin
			wait_idle();
			tx_idle_en = ($urandom_range(0, 3) != 0) && (phase != 1);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			if (phase == 0 || $urandom_range(0, 9) != 0)
				random_setup(page_cnt);
			if ($urandom_range(0, 9) != 0) begin
				queue_req(KIND_INIT, {$urandom, $urandom});
				rand_sent++;
			end
			n = $urandom_range(30, 70);
			for (i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				if (r < 46)
					queue_req(KIND_ALLOC, {$urandom, $urandom});
				else if (r < 92)
					queue_req(KIND_FREE, pick_free_addr(page_cnt));
				else if (r < 97)
					queue_req(KIND_INIT, {$urandom, $urandom});
				else
					queue_req(KIND_UNUSED, {$urandom, $urandom});
			end
			rand_sent += n;
			if (phase == 1)
				@(posedge clk) rx_hold_req = 1'b1;
			phase++;
		end

		wait_idle();
		if (err_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
